FILE: sv/rdle_pkg.sv
`default_nettype none

package rdle_pkg;

  localparam int MAX_RESULTS = 64;
  localparam int AGE_W = 10;
  localparam logic [AGE_W-1:0] AGE_MAX = 10'd1023;

  localparam logic [2:0] OP_OPEN  = 3'd0;
  localparam logic [2:0] OP_CLOSE = 3'd1;
  localparam logic [2:0] OP_CTRL  = 3'd2;
  localparam logic [2:0] OP_SEND  = 3'd3;
  localparam logic [2:0] OP_ACK   = 3'd4;
  localparam logic [2:0] OP_TICK  = 3'd5;

  localparam logic [2:0] LS_CLOSED      = 3'd0;
  localparam logic [2:0] LS_ESTABLISHED = 3'd1;
  localparam logic [2:0] LS_SYN_SENT    = 3'd2;
  localparam logic [2:0] LS_SYN_RCVD    = 3'd3;
  localparam logic [2:0] LS_FIN_SENT    = 3'd4;
  localparam logic [2:0] LS_FIN_RCVD    = 3'd5;

  localparam logic [2:0] C_SYN      = 3'd0;
  localparam logic [2:0] C_SYN_RCVD = 3'd1;
  localparam logic [2:0] C_FIN      = 3'd2;
  localparam logic [2:0] C_FIN_RCVD = 3'd3;
  localparam logic [2:0] C_ACK      = 3'd4;

  localparam logic [1:0] K_STATUS = 2'd0;
  localparam logic [1:0] K_CTRL   = 2'd1;
  localparam logic [1:0] K_RETX   = 2'd2;
  localparam logic [1:0] K_CLOSED = 2'd3;

  localparam logic [1:0] CFG_RETX  = 2'd0;
  localparam logic [1:0] CFG_GIVE  = 2'd1;
  localparam logic [1:0] CFG_IDLE  = 2'd2;

  typedef struct packed {
    logic [7:0]       idx;
    logic [15:0]      handle;
    logic [15:0]      length;
    logic [AGE_W-1:0] first_age;
    logic [AGE_W-1:0] last_age;
  } wait_rec_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  ctl;
    logic [7:0]  idx;
    logic [15:0] handle;
    logic [15:0] length;
    logic        acc;
  } result_t;

  typedef struct packed {
    logic       reply_v;
    logic [2:0] reply;
    logic [2:0] next_state;
  } hs_t;

  function automatic logic [AGE_W-1:0] age_up(input logic [AGE_W-1:0] a);
    age_up = (a == AGE_MAX) ? AGE_MAX : a + 1'b1;
  endfunction

endpackage

`default_nettype wire

FILE: sv/rdle_handshake.sv
`default_nettype none

module rdle_handshake (
  input  wire logic [2:0] cur_state,
  input  wire logic [2:0] code,
  output rdle_pkg::hs_t   hs
);

  always_comb begin
    hs.reply_v    = 1'b0;
    hs.reply      = rdle_pkg::C_SYN;
    hs.next_state = cur_state;
    if (code == rdle_pkg::C_SYN) begin
      hs.next_state = rdle_pkg::LS_SYN_RCVD;
      hs.reply_v    = 1'b1;
      hs.reply      = rdle_pkg::C_SYN_RCVD;
    end else if (code == rdle_pkg::C_FIN) begin
      hs.next_state = rdle_pkg::LS_FIN_RCVD;
      hs.reply_v    = 1'b1;
      hs.reply      = rdle_pkg::C_FIN_RCVD;
    end else if (cur_state == rdle_pkg::LS_SYN_SENT && code == rdle_pkg::C_SYN_RCVD) begin
      hs.next_state = rdle_pkg::LS_ESTABLISHED;
      hs.reply_v    = 1'b1;
      hs.reply      = rdle_pkg::C_ACK;
    end else if (cur_state == rdle_pkg::LS_SYN_RCVD && code == rdle_pkg::C_ACK) begin
      hs.next_state = rdle_pkg::LS_ESTABLISHED;
    end else if (cur_state == rdle_pkg::LS_FIN_SENT && code == rdle_pkg::C_FIN_RCVD) begin
      hs.next_state = rdle_pkg::LS_CLOSED;
      hs.reply_v    = 1'b1;
      hs.reply      = rdle_pkg::C_ACK;
    end else if (cur_state == rdle_pkg::LS_FIN_RCVD && code == rdle_pkg::C_ACK) begin
      hs.next_state = rdle_pkg::LS_CLOSED;
    end
  end

endmodule

`default_nettype wire

FILE: sv/reliable_datagram_link_engine_top.sv
`default_nettype none

// Link engine for one reliable datagram link: handshake state plus a table
// of unacknowledged packets kept in a synchronous memory.
// A command is taken on a clock edge where start is high and busy is low.
// Each result appears on the out_ ports for one cycle with out_valid high;
// the receiver cannot stall, so it must take every strobed result.
// out_last_of_run marks the final result of a command, and busy falls in
// the cycle that result is shown.
// A safe send scans the valid bits one slot per cycle. An ack reads the
// table one entry per cycle. Unless the idle limit tears the link down, a
// tick makes two passes through the table memory (aging, then retransmit);
// the memory has a single read port.
// The configuration port is always ready and is to be written only while
// busy is low; the block itself does not enforce this.
// Reset closes the link, clears all valid bits and restores the register
// defaults; the table memory itself is not cleared.

module reliable_datagram_link_engine_top #(
  parameter int WAIT_DEPTH = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  in_operation,
  input  wire logic [2:0]  in_control_code,
  input  wire logic [7:0]  in_ack_index,
  input  wire logic [15:0] in_packet_handle,
  input  wire logic [15:0] in_packet_length,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [9:0]  cfg_data,
  output logic             out_valid,
  output logic [1:0]       out_result_kind,
  output logic [2:0]       out_reply_control,
  output logic [7:0]       out_index,
  output logic [15:0]      out_handle,
  output logic [15:0]      out_length,
  output logic [2:0]       out_link_status,
  output logic             out_accepted,
  output logic             out_last_of_run
);

  localparam int AW = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
  localparam int CW = $clog2(WAIT_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(WAIT_DEPTH);
  localparam logic [CW-1:0] LAST_C  = CW'(WAIT_DEPTH - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SEND = 3'd1;
  localparam logic [2:0] S_ACK  = 3'd2;
  localparam logic [2:0] S_AGE  = 3'd3;
  localparam logic [2:0] S_RTX  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;
  localparam logic [2:0] S_CTRL = 3'd6;

  rdle_pkg::wait_rec_t mem [WAIT_DEPTH];

  logic [2:0]  st_r, st_nxt;
  logic [2:0]  link_r, link_nxt;
  logic [7:0]  nidx_r, nidx_nxt;
  logic [9:0]  idle_r, idle_nxt;
  logic [WAIT_DEPTH-1:0] valid_r, valid_nxt;
  logic [9:0]  ri_r, gl_r, il_r;
  logic [7:0]  ack_idx_r;
  logic [15:0] handle_r, len_r;
  logic [2:0]  code_r;
  logic [CW-1:0] ra_r, ra_nxt;
  logic        pv_r, pv_nxt;
  logic [AW-1:0] pa_r, pa_nxt;
  rdle_pkg::wait_rec_t rdata_r;
  logic        gf_r, gf_nxt;
  logic [CW-1:0] g_r, g_nxt;
  logic [6:0]  n_r, n_nxt;
  logic        wasc_r, wasc_nxt;
  logic        pend_v_r, pend_v_nxt;
  rdle_pkg::result_t pend_r, pend_nxt;
  logic        out_v_r, out_v_nxt;
  logic        out_last_r, out_last_nxt;
  logic [2:0]  out_stat_r, out_stat_nxt;
  rdle_pkg::result_t out_r, out_nxt;

  logic        push;
  rdle_pkg::result_t push_rec;
  logic        we;
  logic [AW-1:0] wa;
  rdle_pkg::wait_rec_t wd;
  logic        issue;
  logic [CW-1:0] lim;
  logic        done;
  rdle_pkg::wait_rec_t aged;
  logic [9:0]  idle_aged;
  logic [6:0]  cap;
  rdle_pkg::hs_t hs;

  rdle_handshake u_hs (
    .cur_state (link_r),
    .code      (code_r),
    .hs        (hs)
  );

  assign busy      = (st_r != S_IDLE);
  assign cfg_ready = 1'b1;

  assign lim   = (st_r == S_RTX) ? g_r : DEPTH_C;
  assign issue = (st_r == S_ACK || st_r == S_AGE || st_r == S_RTX) && (ra_r != lim);
  assign done  = (ra_r == lim) && !pv_r;
  assign idle_aged = rdle_pkg::age_up(idle_r);
  assign cap = gf_r ? 7'(rdle_pkg::MAX_RESULTS - 1) : 7'(rdle_pkg::MAX_RESULTS);

  always_comb begin
    aged = rdata_r;
    aged.first_age = rdle_pkg::age_up(rdata_r.first_age);
    aged.last_age  = rdle_pkg::age_up(rdata_r.last_age);
  end

  always_comb begin
    st_nxt     = st_r;
    link_nxt   = link_r;
    nidx_nxt   = nidx_r;
    idle_nxt   = idle_r;
    valid_nxt  = valid_r;
    ra_nxt     = ra_r;
    pv_nxt     = issue;
    pa_nxt     = ra_r[AW-1:0];
    gf_nxt     = gf_r;
    g_nxt      = g_r;
    n_nxt      = n_r;
    wasc_nxt   = wasc_r;
    push       = 1'b0;
    push_rec   = '0;
    we         = 1'b0;
    wa         = pa_r;
    wd         = rdata_r;
    if (issue) begin
      ra_nxt = ra_r + 1'b1;
    end
    case (st_r)
      S_IDLE: begin
        if (start) begin
          ra_nxt = '0;
          case (in_operation)
            rdle_pkg::OP_OPEN: begin
              link_nxt      = rdle_pkg::LS_SYN_SENT;
              idle_nxt      = '0;
              push          = 1'b1;
              push_rec.kind = rdle_pkg::K_CTRL;
              push_rec.ctl  = rdle_pkg::C_SYN;
              st_nxt        = S_FIN;
            end
            rdle_pkg::OP_CLOSE: begin
              link_nxt      = rdle_pkg::LS_FIN_SENT;
              push          = 1'b1;
              push_rec.kind = rdle_pkg::K_CTRL;
              push_rec.ctl  = rdle_pkg::C_FIN;
              st_nxt        = S_FIN;
            end
            rdle_pkg::OP_CTRL: begin
              idle_nxt = '0;
              st_nxt   = S_CTRL;
            end
            rdle_pkg::OP_SEND: begin
              st_nxt = S_SEND;
            end
            rdle_pkg::OP_ACK: begin
              st_nxt = S_ACK;
            end
            rdle_pkg::OP_TICK: begin
              if (link_r != rdle_pkg::LS_ESTABLISHED
                  && !(link_r == rdle_pkg::LS_CLOSED && !(|valid_r))
                  && idle_aged > il_r) begin
                valid_nxt     = '0;
                link_nxt      = rdle_pkg::LS_CLOSED;
                idle_nxt      = '0;
                nidx_nxt      = '0;
                push          = 1'b1;
                push_rec.kind = rdle_pkg::K_CLOSED;
                st_nxt        = S_FIN;
              end else begin
                idle_nxt = idle_aged;
                gf_nxt   = 1'b0;
                g_nxt    = DEPTH_C;
                n_nxt    = '0;
                wasc_nxt = (link_r == rdle_pkg::LS_CLOSED);
                st_nxt   = S_AGE;
              end
            end
            default: begin
              st_nxt = S_FIN;
            end
          endcase
        end
      end
      S_CTRL: begin
        link_nxt = hs.next_state;
        if (hs.reply_v) begin
          push          = 1'b1;
          push_rec.kind = rdle_pkg::K_CTRL;
          push_rec.ctl  = hs.reply;
        end
        st_nxt = S_FIN;
      end
      S_SEND: begin
        if (!valid_r[ra_r[AW-1:0]]) begin
          we             = 1'b1;
          wa             = ra_r[AW-1:0];
          wd.idx         = nidx_r;
          wd.handle      = handle_r;
          wd.length      = len_r;
          wd.first_age   = '0;
          wd.last_age    = '0;
          valid_nxt[ra_r[AW-1:0]] = 1'b1;
          push           = 1'b1;
          push_rec.idx   = nidx_r;
          push_rec.acc   = 1'b1;
          nidx_nxt       = nidx_r + 1'b1;
          st_nxt         = S_FIN;
        end else if (ra_r == LAST_C) begin
          st_nxt = S_FIN;
        end else begin
          ra_nxt = ra_r + 1'b1;
        end
      end
      S_ACK: begin
        if (pv_r && valid_r[pa_r] && rdata_r.idx == ack_idx_r) begin
          valid_nxt[pa_r] = 1'b0;
          push            = 1'b1;
          push_rec.idx    = ack_idx_r;
          push_rec.acc    = 1'b1;
          st_nxt          = S_FIN;
        end else if (done) begin
          push         = 1'b1;
          push_rec.idx = ack_idx_r;
          st_nxt       = S_FIN;
        end
      end
      S_AGE: begin
        if (pv_r && valid_r[pa_r]) begin
          we = 1'b1;
          wd = aged;
          if (!gf_r && aged.first_age > gl_r) begin
            gf_nxt = 1'b1;
            g_nxt  = CW'(pa_r);
          end
        end
        if (done) begin
          if (gf_r) begin
            link_nxt = rdle_pkg::LS_CLOSED;
          end
          ra_nxt = '0;
          st_nxt = S_RTX;
        end
      end
      S_RTX: begin
        if (pv_r && valid_r[pa_r] && rdata_r.last_age > ri_r && n_r < cap) begin
          we              = 1'b1;
          wd.last_age     = '0;
          push            = 1'b1;
          push_rec.kind   = rdle_pkg::K_RETX;
          push_rec.idx    = rdata_r.idx;
          push_rec.handle = rdata_r.handle;
          push_rec.length = rdata_r.length;
          n_nxt           = n_r + 1'b1;
        end
        if (done) begin
          if (gf_r && !wasc_r) begin
            push          = 1'b1;
            push_rec.kind = rdle_pkg::K_CLOSED;
          end
          st_nxt = S_FIN;
        end
      end
      S_FIN: begin
        st_nxt = S_IDLE;
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    pend_v_nxt   = pend_v_r;
    pend_nxt     = pend_r;
    out_v_nxt    = 1'b0;
    out_nxt      = out_r;
    out_last_nxt = 1'b0;
    out_stat_nxt = out_stat_r;
    if (st_r == S_FIN) begin
      out_v_nxt    = 1'b1;
      out_nxt      = pend_v_r ? pend_r : '0;
      out_last_nxt = 1'b1;
      out_stat_nxt = link_r;
      pend_v_nxt   = 1'b0;
    end else if (push) begin
      if (pend_v_r) begin
        out_v_nxt    = 1'b1;
        out_nxt      = pend_r;
        out_stat_nxt = link_r;
      end
      pend_v_nxt = 1'b1;
      pend_nxt   = push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (issue) begin
      rdata_r <= mem[ra_r[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= S_IDLE;
      link_r     <= rdle_pkg::LS_CLOSED;
      nidx_r     <= '0;
      idle_r     <= '0;
      valid_r    <= '0;
      ri_r       <= 10'd5;
      gl_r       <= 10'd50;
      il_r       <= 10'd50;
      pv_r       <= 1'b0;
      pend_v_r   <= 1'b0;
      out_v_r    <= 1'b0;
      out_last_r <= 1'b0;
      gf_r       <= 1'b0;
      wasc_r     <= 1'b0;
      n_r        <= '0;
      ra_r       <= '0;
      g_r        <= DEPTH_C;
    end else begin
      st_r       <= st_nxt;
      link_r     <= link_nxt;
      nidx_r     <= nidx_nxt;
      idle_r     <= idle_nxt;
      valid_r    <= valid_nxt;
      pv_r       <= pv_nxt;
      pend_v_r   <= pend_v_nxt;
      out_v_r    <= out_v_nxt;
      out_last_r <= out_last_nxt;
      gf_r       <= gf_nxt;
      wasc_r     <= wasc_nxt;
      n_r        <= n_nxt;
      ra_r       <= ra_nxt;
      g_r        <= g_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          rdle_pkg::CFG_RETX: ri_r <= cfg_data;
          rdle_pkg::CFG_GIVE: gl_r <= cfg_data;
          rdle_pkg::CFG_IDLE: il_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    pa_r       <= pa_nxt;
    out_r      <= out_nxt;
    out_stat_r <= out_stat_nxt;
    pend_r     <= pend_nxt;
    if (st_r == S_IDLE && start) begin
      code_r    <= in_control_code;
      ack_idx_r <= in_ack_index;
      handle_r  <= in_packet_handle;
      len_r     <= in_packet_length;
    end
  end

  assign out_valid         = out_v_r;
  assign out_result_kind   = out_r.kind;
  assign out_reply_control = out_r.ctl;
  assign out_index         = out_r.idx;
  assign out_handle        = out_r.handle;
  assign out_length        = out_r.length;
  assign out_link_status   = out_stat_r;
  assign out_accepted      = out_r.acc;
  assign out_last_of_run   = out_last_r;

`ifndef ASSERT_OFF
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("command taken but engine not busy");
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_of_run) |-> !busy)
    else $error("final result shown while still busy");
  a_retx_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result_kind == rdle_pkg::K_RETX && !out_last_of_run) |-> busy)
    else $error("retransmit shown outside a tick scan");
`endif

endmodule

`default_nettype wire

FILE: dv/testbench.sv
`default_nettype none

module testbench;

  localparam int DEPTH = 64;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  ctl;
    logic [7:0]  idx;
    logic [15:0] handle;
    logic [15:0] length;
    logic [2:0]  status;
    logic        acc;
    logic        last;
  } link_result_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [2:0]  in_operation;
  logic [2:0]  in_control_code;
  logic [7:0]  in_ack_index;
  logic [15:0] in_packet_handle;
  logic [15:0] in_packet_length;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [9:0]  cfg_data;
  logic        out_valid;
  logic [1:0]  out_result_kind;
  logic [2:0]  out_reply_control;
  logic [7:0]  out_index;
  logic [15:0] out_handle;
  logic [15:0] out_length;
  logic [2:0]  out_link_status;
  logic        out_accepted;
  logic        out_last_of_run;

  reliable_datagram_link_engine_top uut (.*);

  // Predictor state.
  logic [9:0]  retx_interval;
  logic [9:0]  give_limit;
  logic [9:0]  idle_limit;
  logic [2:0]  pred_state;
  logic [7:0]  next_index;
  logic [9:0]  idle_ticks;
  logic        slot_valid [DEPTH];
  logic [7:0]  slot_index [DEPTH];
  logic [15:0] slot_handle [DEPTH];
  logic [15:0] slot_length [DEPTH];
  logic [9:0]  slot_first_age [DEPTH];
  logic [9:0]  slot_last_age [DEPTH];

  link_result_t expected_results[$];
  link_result_t step_results[$];
  int error_count = 0;
  int command_count = 0;
  int result_count = 0;
  int idle_pct = 0;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic logic [9:0] bump_age(logic [9:0] a);
    return (a == 10'd1023) ? a : a + 10'd1;
  endfunction

  function automatic void add_result(logic [1:0] kind, logic [2:0] ctl, logic [7:0] idx,
                                     logic [15:0] h, logic [15:0] l, logic acc);
    link_result_t r;
    if (step_results.size() >= rdle_pkg::MAX_RESULTS) return;
    r = '0;
    r.kind = kind;
    r.ctl = ctl;
    r.idx = idx;
    r.handle = h;
    r.length = l;
    r.acc = acc;
    step_results = {step_results, r};
  endfunction

  function automatic void link_tick();
    int g;
    int cap;
    logic any;
    any = 1'b0;
    idle_ticks = bump_age(idle_ticks);
    for (int i = 0; i < DEPTH; i++) any |= slot_valid[i];
    if (pred_state != rdle_pkg::LS_ESTABLISHED &&
        !(pred_state == rdle_pkg::LS_CLOSED && !any) && idle_ticks > idle_limit) begin
      for (int i = 0; i < DEPTH; i++) slot_valid[i] = 1'b0;
      pred_state = rdle_pkg::LS_CLOSED;
      idle_ticks = '0;
      next_index = '0;
      add_result(rdle_pkg::K_CLOSED, 3'd0, 8'd0, 16'd0, 16'd0, 1'b0);
      return;
    end
    g = DEPTH;
    for (int i = 0; i < DEPTH; i++) begin
      if (slot_valid[i]) begin
        slot_first_age[i] = bump_age(slot_first_age[i]);
        slot_last_age[i] = bump_age(slot_last_age[i]);
        if (g == DEPTH && slot_first_age[i] > give_limit) g = i;
      end
    end
    cap = (g < DEPTH) ? rdle_pkg::MAX_RESULTS - 1 : rdle_pkg::MAX_RESULTS;
    for (int i = 0; i < g; i++) begin
      if (slot_valid[i] && slot_last_age[i] > retx_interval && step_results.size() < cap) begin
        add_result(rdle_pkg::K_RETX, 3'd0, slot_index[i], slot_handle[i], slot_length[i],
                   1'b0);
        slot_last_age[i] = '0;
      end
    end
    if (g < DEPTH && pred_state != rdle_pkg::LS_CLOSED) begin
      pred_state = rdle_pkg::LS_CLOSED;
      add_result(rdle_pkg::K_CLOSED, 3'd0, 8'd0, 16'd0, 16'd0, 1'b0);
    end
  endfunction

  function automatic void predict_link_step(logic [2:0] op, logic [2:0] code, logic [7:0] aidx,
                                            logic [15:0] h, logic [15:0] l);
    logic found;
    link_result_t r;
    step_results.delete();
    found = 1'b0;
    case (op)
      rdle_pkg::OP_OPEN: begin
        pred_state = rdle_pkg::LS_SYN_SENT;
        idle_ticks = '0;
        add_result(rdle_pkg::K_CTRL, rdle_pkg::C_SYN, 8'd0, 16'd0, 16'd0, 1'b0);
      end
      rdle_pkg::OP_CLOSE: begin
        pred_state = rdle_pkg::LS_FIN_SENT;
        add_result(rdle_pkg::K_CTRL, rdle_pkg::C_FIN, 8'd0, 16'd0, 16'd0, 1'b0);
      end
      rdle_pkg::OP_CTRL: begin
        idle_ticks = '0;
        if (code == rdle_pkg::C_SYN) begin
          pred_state = rdle_pkg::LS_SYN_RCVD;
          add_result(rdle_pkg::K_CTRL, rdle_pkg::C_SYN_RCVD, 8'd0, 16'd0, 16'd0, 1'b0);
        end else if (code == rdle_pkg::C_FIN) begin
          pred_state = rdle_pkg::LS_FIN_RCVD;
          add_result(rdle_pkg::K_CTRL, rdle_pkg::C_FIN_RCVD, 8'd0, 16'd0, 16'd0, 1'b0);
        end else if (pred_state == rdle_pkg::LS_SYN_SENT && code == rdle_pkg::C_SYN_RCVD) begin
          pred_state = rdle_pkg::LS_ESTABLISHED;
          add_result(rdle_pkg::K_CTRL, rdle_pkg::C_ACK, 8'd0, 16'd0, 16'd0, 1'b0);
        end else if (pred_state == rdle_pkg::LS_SYN_RCVD && code == rdle_pkg::C_ACK) begin
          pred_state = rdle_pkg::LS_ESTABLISHED;
        end else if (pred_state == rdle_pkg::LS_FIN_SENT && code == rdle_pkg::C_FIN_RCVD) begin
          pred_state = rdle_pkg::LS_CLOSED;
          add_result(rdle_pkg::K_CTRL, rdle_pkg::C_ACK, 8'd0, 16'd0, 16'd0, 1'b0);
        end else if (pred_state == rdle_pkg::LS_FIN_RCVD && code == rdle_pkg::C_ACK) begin
          pred_state = rdle_pkg::LS_CLOSED;
        end
      end
      rdle_pkg::OP_SEND: begin
        for (int i = 0; i < DEPTH && !found; i++) begin
          if (!slot_valid[i]) begin
            found = 1'b1;
            slot_valid[i] = 1'b1;
            slot_index[i] = next_index;
            slot_handle[i] = h;
            slot_length[i] = l;
            slot_first_age[i] = '0;
            slot_last_age[i] = '0;
            add_result(rdle_pkg::K_STATUS, 3'd0, next_index, 16'd0, 16'd0, 1'b1);
            next_index = next_index + 8'd1;
          end
        end
        if (!found) add_result(rdle_pkg::K_STATUS, 3'd0, 8'd0, 16'd0, 16'd0, 1'b0);
      end
      rdle_pkg::OP_ACK: begin
        for (int i = 0; i < DEPTH && !found; i++) begin
          if (slot_valid[i] && slot_index[i] == aidx) begin
            found = 1'b1;
            slot_valid[i] = 1'b0;
          end
        end
        add_result(rdle_pkg::K_STATUS, 3'd0, aidx, 16'd0, 16'd0, found);
      end
      rdle_pkg::OP_TICK: link_tick();
      default: ;
    endcase
    if (step_results.size() == 0)
      add_result(rdle_pkg::K_STATUS, 3'd0, 8'd0, 16'd0, 16'd0, 1'b0);
    foreach (step_results[k]) begin
      r = step_results[k];
      r.status = pred_state;
      r.last = (k == step_results.size() - 1);
      expected_results = {expected_results, r};
    end
  endfunction

  task automatic compare_field(string name, logic [15:0] exp, logic [15:0] act);
    if (exp != act) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp, act);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    link_result_t e;
    if (rst_n && out_valid) begin
      result_count++;
      if (expected_results.size() == 0) begin
        $error("result transaction with nothing expected");
        error_count++;
      end else begin
        e = expected_results.pop_front();
        compare_field("result_kind", 16'(e.kind), 16'(out_result_kind));
        compare_field("reply_control", 16'(e.ctl), 16'(out_reply_control));
        compare_field("out_index", 16'(e.idx), 16'(out_index));
        compare_field("out_handle", e.handle, out_handle);
        compare_field("out_length", e.length, out_length);
        compare_field("link_status", 16'(e.status), 16'(out_link_status));
        compare_field("accepted", 16'(e.acc), 16'(out_accepted));
        compare_field("last_of_run", 16'(e.last), 16'(out_last_of_run));
      end
    end
  end

  task automatic send_command(logic [2:0] op, logic [2:0] code, logic [7:0] aidx,
                              logic [15:0] h, logic [15:0] l);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    in_operation <= op;
    in_control_code <= code;
    in_ack_index <= aidx;
    in_packet_handle <= h;
    in_packet_length <= l;
    do @(posedge clk); while (busy);
    predict_link_step(op, code, aidx, h, l);
    command_count++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    start <= 1'b0;
    while (expected_results.size() != 0 || busy) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic write_register(logic [1:0] index, logic [9:0] value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (index)
      rdle_pkg::CFG_RETX: retx_interval = value;
      rdle_pkg::CFG_GIVE: give_limit = value;
      rdle_pkg::CFG_IDLE: idle_limit = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_timers(logic [9:0] retx, logic [9:0] give, logic [9:0] idle);
    write_register(rdle_pkg::CFG_RETX, retx);
    write_register(rdle_pkg::CFG_GIVE, give);
    write_register(rdle_pkg::CFG_IDLE, idle);
  endtask

  task automatic random_command();
    int pick;
    logic [2:0] op;
    logic [7:0] aidx;
    pick = $urandom_range(99);
    aidx = 8'($urandom);
    if (pick < 35) op = rdle_pkg::OP_SEND;
    else if (pick < 60) op = rdle_pkg::OP_ACK;
    else if (pick < 80) op = rdle_pkg::OP_TICK;
    else if (pick < 90) op = rdle_pkg::OP_CTRL;
    else if (pick < 94) op = rdle_pkg::OP_OPEN;
    else if (pick < 98) op = rdle_pkg::OP_CLOSE;
    else op = 3'($urandom_range(6, 7));
    if (op == rdle_pkg::OP_ACK && $urandom_range(3) != 0)
      aidx = next_index - 8'($urandom_range(1, 8));
    send_command(op, 3'($urandom), aidx, 16'($urandom), 16'($urandom));
  endtask

  task automatic test_directed();
    send_command(rdle_pkg::OP_CTRL, rdle_pkg::C_ACK, 8'd0, 16'd0, 16'd0);
    send_command(rdle_pkg::OP_OPEN, 3'd0, 8'd0, 16'd0, 16'd0);
    send_command(rdle_pkg::OP_CTRL, rdle_pkg::C_SYN_RCVD, 8'd0, 16'd0, 16'd0);
    send_command(rdle_pkg::OP_SEND, 3'd0, 8'd0, 16'hFFFF, 16'hFFFF);
    send_command(rdle_pkg::OP_SEND, 3'd0, 8'd0, 16'h0000, 16'h0000);
    send_command(rdle_pkg::OP_ACK, 3'd0, 8'd0, 16'd0, 16'd0);
    send_command(rdle_pkg::OP_ACK, 3'd0, 8'd255, 16'd0, 16'd0);
    send_command(rdle_pkg::OP_CTRL, 3'd5, 8'd0, 16'd0, 16'd0);
    send_command(rdle_pkg::OP_CTRL, 3'd7, 8'd0, 16'd0, 16'd0);
    send_command(3'd6, 3'd0, 8'd0, 16'd0, 16'd0);
    send_command(3'd7, 3'd7, 8'hFF, 16'hFFFF, 16'hFFFF);
    send_command(rdle_pkg::OP_TICK, 3'd0, 8'd0, 16'd0, 16'd0);
    send_command(rdle_pkg::OP_CLOSE, 3'd0, 8'd0, 16'd0, 16'd0);
    send_command(rdle_pkg::OP_CTRL, rdle_pkg::C_FIN_RCVD, 8'd0, 16'd0, 16'd0);
    send_command(rdle_pkg::OP_CTRL, rdle_pkg::C_SYN, 8'd0, 16'd0, 16'd0);
    send_command(rdle_pkg::OP_CTRL, rdle_pkg::C_ACK, 8'd0, 16'd0, 16'd0);
    send_command(rdle_pkg::OP_CTRL, rdle_pkg::C_FIN, 8'd0, 16'd0, 16'd0);
    send_command(rdle_pkg::OP_CTRL, rdle_pkg::C_ACK, 8'd0, 16'd0, 16'd0);
    send_command(rdle_pkg::OP_ACK, 3'd0, 8'd1, 16'd0, 16'd0);
    for (int i = 0; i < 5; i++) send_command(rdle_pkg::OP_TICK, 3'd0, 8'd0, 16'd0, 16'd0);
  endtask

  // Fill past the table depth, then age it so every entry is due at once
  // and later beyond the give-up limit.
  task automatic test_full_table();
    set_timers(10'd1, 10'd4, 10'd1023);
    send_command(rdle_pkg::OP_OPEN, 3'd0, 8'd0, 16'd0, 16'd0);
    send_command(rdle_pkg::OP_CTRL, rdle_pkg::C_SYN_RCVD, 8'd0, 16'd0, 16'd0);
    for (int i = 0; i < DEPTH + 2; i++)
      send_command(rdle_pkg::OP_SEND, 3'd0, 8'd0, 16'($urandom), 16'($urandom));
    for (int i = 0; i < 7; i++) send_command(rdle_pkg::OP_TICK, 3'd0, 8'd0, 16'd0, 16'd0);
    wait_drained();
    send_command(rdle_pkg::OP_ACK, 3'd0, 8'd3, 16'd0, 16'd0);
    send_command(rdle_pkg::OP_CLOSE, 3'd0, 8'd0, 16'd0, 16'd0);
    for (int i = 0; i < 3; i++) send_command(rdle_pkg::OP_TICK, 3'd0, 8'd0, 16'd0, 16'd0);
  endtask

  task automatic test_idle_teardown();
    set_timers(10'd1023, 10'd1023, 10'd2);
    send_command(rdle_pkg::OP_OPEN, 3'd0, 8'd0, 16'd0, 16'd0);
    send_command(rdle_pkg::OP_SEND, 3'd0, 8'd0, 16'h1234, 16'h0042);
    for (int i = 0; i < 4; i++) send_command(rdle_pkg::OP_TICK, 3'd0, 8'd0, 16'd0, 16'd0);
  endtask

  task automatic test_random(int pct, int count, logic [9:0] retx, logic [9:0] give,
                             logic [9:0] idle);
    set_timers(retx, give, idle);
    idle_pct = pct;
    for (int i = 0; i < count; i++) random_command();
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_operation = '0;
    in_control_code = '0;
    in_ack_index = '0;
    in_packet_handle = '0;
    in_packet_length = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    retx_interval = 10'd5;
    give_limit = 10'd50;
    idle_limit = 10'd50;
    pred_state = rdle_pkg::LS_CLOSED;
    next_index = '0;
    idle_ticks = '0;
    for (int i = 0; i < DEPTH; i++) begin
      slot_valid[i] = 1'b0;
      slot_index[i] = '0;
      slot_handle[i] = '0;
      slot_length[i] = '0;
      slot_first_age[i] = '0;
      slot_last_age[i] = '0;
    end
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_full_table();
    test_idle_teardown();
    test_random(0, 25, 10'd3, 10'd20, 10'd15);
    test_random(57, 25, 10'd1, 10'd1, 10'd1);
    test_random(21, 25, 10'd1023, 10'd1023, 10'd1023);
    test_random(0, 25, 10'd2, 10'd30, 10'd1023);
    wait_drained();
    repeat (150) @(posedge clk);
    $display("Covered handshake, full table, give-up, idle teardown and random traffic:");
    $display("%0d command transactions, %0d result transactions.", command_count, result_count);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("FAILURE");
    $finish;
  end

endmodule

`default_nettype wire
